### sv/lrfd_pkg.sv
`timescale 1ns / 1ps

package lrfd_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_BITS   = 32;
    localparam int COLOR_BITS = 16;
    localparam int CFG_BITS   = 12;
    localparam int SPAN_BITS  = COORD_BITS + 1;

    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int STEP_BITS  = $clog2(DIV_STEPS);

    localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = CFG_BITS'(480);

    localparam logic [ACC_BITS-1:0] ACC_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic
    {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } operation_t;

    typedef enum logic
    {
        ST_IDLE   = 1'b0,
        ST_DIVIDE = 1'b1
    } state_t;

    typedef struct packed
    {
        logic                         operation;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic        [COLOR_BITS-1:0] line_color;
    } in_item_t;

    typedef struct packed
    {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         visible;
        logic        [COLOR_BITS-1:0] pixel_color;
        logic                         last;
    } out_item_t;

endpackage

### sv/line_rasterizer_fixed_dda.sv
`timescale 1ns / 1ps

// Fixed-point DDA line rasteriser. A start transaction latches two endpoints and a colour and
// produces no pixel; the block then works out the 16.16 slope with a restore-and-shift divider
// that yields one quotient bit per cycle, so in_ready stays low while it divides. Each advance
// transaction taken while a line is active yields one pixel transaction carrying its coordinates,
// the clip result against frame_width and frame_height, the colour and a last flag at the end
// point; an advance with no line active yields nothing. Advance transactions are taken one per
// cycle while the output register is empty or being drained. The user writes the frame size
// through cfg_we, cfg_index and cfg_data only while the block is idle, which it does not enforce.
module line_rasterizer_fixed_dda
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [lrfd_pkg::CFG_BITS-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  lrfd_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output lrfd_pkg::out_item_t                out_data
);
    import lrfd_pkg::*;

    state_t                        state_reg, state_next;
    logic [CFG_BITS-1:0]           frame_width_reg, frame_height_reg;
    logic                          active_reg, active_next;
    logic                          major_is_y_reg, major_is_y_next;
    logic                          step_down_reg, step_down_next;
    logic                          minor_neg_reg, minor_neg_next;
    logic                          div_zero_reg, div_zero_next;
    logic signed [COORD_BITS-1:0]  major_pos_reg, major_pos_next;
    logic signed [COORD_BITS-1:0]  major_end_reg, major_end_next;
    logic [ACC_BITS-1:0]           minor_accum_reg, minor_accum_next;
    logic [ACC_BITS-1:0]           slope_reg, slope_next;
    logic [COLOR_BITS-1:0]         held_color_reg, held_color_next;
    logic [SPAN_BITS-1:0]          div_rem_reg, div_rem_next;
    logic [COORD_BITS-1:0]         div_maj_reg, div_maj_next;
    logic [FRAC_BITS-1:0]          quot_reg, quot_next;
    logic [STEP_BITS-1:0]          step_reg, step_next;
    logic                          out_valid_reg, out_valid_next;
    out_item_t                     out_data_reg, out_data_next;

    logic                          in_fire, start_fire, adv_fire, div_done;
    logic signed [SPAN_BITS-1:0]   dx, dy;
    logic [COORD_BITS-1:0]         adx, ady;
    logic                          pick_y;
    logic [SPAN_BITS:0]            trial;
    logic                          fits;
    logic [FRAC_BITS:0]            quot_final;
    logic [ACC_BITS-1:0]           quot_wide;
    logic signed [COORD_BITS-1:0]  minor_coord, px, py, minor_start;
    logic                          is_last, px_in, py_in;

    // Operand preparation for a start transaction.
    always_comb
    begin
        dx     = SPAN_BITS'(in_data.end_x) - SPAN_BITS'(in_data.start_x);
        dy     = SPAN_BITS'(in_data.end_y) - SPAN_BITS'(in_data.start_y);
        adx    = dx[SPAN_BITS-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
        ady    = dy[SPAN_BITS-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
        pick_y = ady > adx;
        minor_start = pick_y ? in_data.start_x : in_data.start_y;
    end

    // One divider step: trial subtract, keep or restore, shift.
    always_comb
    begin
        trial      = {1'b0, div_rem_reg} - {2'b00, div_maj_reg};
        fits       = !trial[SPAN_BITS];
        quot_final = {quot_reg, fits};
        quot_wide  = ACC_BITS'(quot_final);
    end

    // Pixel generation from the current line state.
    always_comb
    begin
        minor_coord = minor_accum_reg[FRAC_BITS +: COORD_BITS];
        px      = major_is_y_reg ? minor_coord : major_pos_reg;
        py      = major_is_y_reg ? major_pos_reg : minor_coord;
        is_last = major_pos_reg == major_end_reg;
        px_in   = !px[COORD_BITS-1] && (CFG_BITS'(px) < frame_width_reg);
        py_in   = !py[COORD_BITS-1] && (CFG_BITS'(py) < frame_height_reg);
    end

    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
        in_fire    = in_valid && in_ready;
        start_fire = in_fire && (in_data.operation == OP_START);
        adv_fire   = in_fire && (in_data.operation == OP_ADVANCE) && active_reg;
        div_done   = (state_reg == ST_DIVIDE) && (step_reg == STEP_BITS'(DIV_STEPS - 1));
        out_valid  = out_valid_reg;
        out_data   = out_data_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_fire)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        active_next      = active_reg;
        major_is_y_next  = major_is_y_reg;
        step_down_next   = step_down_reg;
        minor_neg_next   = minor_neg_reg;
        div_zero_next    = div_zero_reg;
        major_pos_next   = major_pos_reg;
        major_end_next   = major_end_reg;
        minor_accum_next = minor_accum_reg;
        slope_next       = slope_reg;
        held_color_next  = held_color_reg;
        div_rem_next     = div_rem_reg;
        div_maj_next     = div_maj_reg;
        quot_next        = quot_reg;
        step_next        = step_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_data_next    = out_data_reg;

        if (start_fire)
        begin
            active_next      = 1'b1;
            major_is_y_next  = pick_y;
            step_down_next   = pick_y ? dy[SPAN_BITS-1] : dx[SPAN_BITS-1];
            minor_neg_next   = pick_y ? dx[SPAN_BITS-1] : dy[SPAN_BITS-1];
            div_zero_next    = (pick_y ? ady : adx) == '0;
            major_pos_next   = pick_y ? in_data.start_y : in_data.start_x;
            major_end_next   = pick_y ? in_data.end_y : in_data.end_x;
            minor_accum_next = ACC_HALF + (ACC_BITS'(minor_start) << FRAC_BITS);
            held_color_next  = in_data.line_color;
            div_rem_next     = SPAN_BITS'(pick_y ? adx : ady);
            div_maj_next     = pick_y ? ady : adx;
            quot_next        = '0;
            step_next        = '0;
        end

        if (state_reg == ST_DIVIDE)
        begin
            div_rem_next = {(fits ? trial[COORD_BITS-1:0] : div_rem_reg[COORD_BITS-1:0]), 1'b0};
            quot_next    = quot_final[FRAC_BITS-1:0];
            step_next    = step_reg + STEP_BITS'(1);
            if (div_done)
            begin
                if (div_zero_reg)
                begin
                    slope_next = '0;
                end
                else
                begin
                    slope_next = minor_neg_reg ? (~quot_wide + ACC_BITS'(1)) : quot_wide;
                end
            end
        end

        if (adv_fire)
        begin
            out_valid_next            = 1'b1;
            out_data_next.pixel_x     = px;
            out_data_next.pixel_y     = py;
            out_data_next.visible     = px_in && py_in;
            out_data_next.pixel_color = held_color_reg;
            out_data_next.last        = is_last;
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                major_pos_next   = step_down_reg ? major_pos_reg - COORD_BITS'(1)
                                                 : major_pos_reg + COORD_BITS'(1);
                minor_accum_next = minor_accum_reg + slope_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            active_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            step_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            if (cfg_we && (cfg_index == REG_FRAME_WIDTH))
            begin
                frame_width_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_FRAME_HEIGHT))
            begin
                frame_height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        major_is_y_reg  <= major_is_y_next;
        step_down_reg   <= step_down_next;
        minor_neg_reg   <= minor_neg_next;
        div_zero_reg    <= div_zero_next;
        major_pos_reg   <= major_pos_next;
        major_end_reg   <= major_end_next;
        minor_accum_reg <= minor_accum_next;
        slope_reg       <= slope_next;
        held_color_reg  <= held_color_next;
        div_rem_reg     <= div_rem_next;
        div_maj_reg     <= div_maj_next;
        quot_reg        <= quot_next;
        out_data_reg    <= out_data_next;
    end

endmodule
